FILE: hw/rtl/rta_pkg.sv
// rta_pkg: shared types, constants and helper functions of the pose accumulator
// element format, beat structs, saturation and rounding helpers, series tables
// no dependencies
package rta_pkg;

    localparam int ELEM_W     = 32;
    localparam int FRAC_BITS  = 16;
    localparam int HALF_TURN  = 180;
    localparam int POSE_ROWS  = 3;
    localparam int ROW_COLS   = 4;
    localparam int ROW_W      = ELEM_W * ROW_COLS;
    localparam int COEF_W     = FRAC_BITS + 2;
    localparam int PROD_W     = ELEM_W + COEF_W - 1;
    localparam int MAG_W      = PROD_W - FRAC_BITS + 1;

    localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic [ELEM_W-1:0] ELEM_ONE = ELEM_W'(1) << FRAC_BITS;

    localparam logic       ACT_ROTATE    = 1'b0;
    localparam logic       ACT_TRANSLATE = 1'b1;
    localparam logic [1:0] AXIS_X        = 2'd0;
    localparam logic [1:0] AXIS_Y        = 2'd1;
    localparam logic [1:0] AXIS_Z        = 2'd2;
    localparam logic [1:0] AXIS_NONE     = 2'd3;
    localparam logic [1:0] ROW_LAST      = 2'd3;

    typedef logic [ELEM_W-1:0] rta_elem_t;
    typedef rta_elem_t [ROW_COLS-1:0] rta_row_t;

    typedef struct packed {
        logic               action;
        logic [1:0]         axis;
        logic signed [31:0] amount;
    } rta_in_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } rta_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] s;
        logic signed [COEF_W-1:0] c;
    } rta_sc_t;

    function automatic rta_elem_t rta_sat_add(input rta_elem_t a, input rta_elem_t b);
        logic [ELEM_W:0] sum;
        sum = {a[ELEM_W-1], a} + {b[ELEM_W-1], b};
        if (sum[ELEM_W] != sum[ELEM_W-1])
            return sum[ELEM_W] ? ELEM_MIN : ELEM_MAX;
        return sum[ELEM_W-1:0];
    endfunction

    // magnitude product back to element scale, half away from zero, saturated
    function automatic rta_elem_t rta_mul_round(input logic [PROD_W-1:0] prod, input logic neg);
        logic [PROD_W:0]  rnd;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] nmag;
        rnd  = {1'b0, prod} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
        mag  = rnd[FRAC_BITS +: MAG_W];
        nmag = MAG_W'(0) - mag;
        if (neg)
            return (mag > MAG_W'(ELEM_MAX)) ? ELEM_MIN : nmag[ELEM_W-1:0];
        return (mag > MAG_W'(ELEM_MAX)) ? ELEM_MAX : mag[ELEM_W-1:0];
    endfunction

    function automatic rta_row_t rta_ident_row(input logic [1:0] r);
        rta_row_t row;
        row    = '0;
        row[r] = ELEM_ONE;
        return row;
    endfunction

    // series term divisors: sine 2k(2k+1), cosine (2k-1)2k
    function automatic logic [7:0] rta_div(input logic want_sin, input logic [2:0] k);
        logic [7:0] d;
        if (want_sin)
        begin
            unique case (k)
                3'd1:    d = 8'd6;
                3'd2:    d = 8'd20;
                3'd3:    d = 8'd42;
                3'd4:    d = 8'd72;
                3'd5:    d = 8'd110;
                3'd6:    d = 8'd156;
                default: d = 8'd6;
            endcase
        end
        else
        begin
            unique case (k)
                3'd1:    d = 8'd2;
                3'd2:    d = 8'd12;
                3'd3:    d = 8'd30;
                3'd4:    d = 8'd56;
                3'd5:    d = 8'd90;
                3'd6:    d = 8'd132;
                3'd7:    d = 8'd182;
                default: d = 8'd2;
            endcase
        end
        return d;
    endfunction

    // floor(2^31 / divisor) for the same terms
    function automatic logic [31:0] rta_recip(input logic want_sin, input logic [2:0] k);
        logic [31:0] m;
        if (want_sin)
        begin
            unique case (k)
                3'd1:    m = 32'd357913941;
                3'd2:    m = 32'd107374182;
                3'd3:    m = 32'd51130563;
                3'd4:    m = 32'd29826161;
                3'd5:    m = 32'd19522578;
                3'd6:    m = 32'd13765920;
                default: m = 32'd357913941;
            endcase
        end
        else
        begin
            unique case (k)
                3'd1:    m = 32'd1073741824;
                3'd2:    m = 32'd178956970;
                3'd3:    m = 32'd71582788;
                3'd4:    m = 32'd38347922;
                3'd5:    m = 32'd23860929;
                3'd6:    m = 32'd16268815;
                3'd7:    m = 32'd11799360;
                default: m = 32'd1073741824;
            endcase
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/rigid_transform_accumulator.sv
// rigid_transform_accumulator: top level of the 4x4 pose accumulator
// pose rows in rta_ram, sine and cosine from rta_trig
// depends on rta_pkg, rta_ram, rta_trig
//
// The pose (rows zero to two, Q16.16, identity after reset) sits in a three-row
// memory; each input beat is read, modified and written back, then the four
// pose rows leave as four output beats, row three always 0,0,0,1. A rotation
// first runs the sine/cosine unit, which evaluates thirteen series terms on its
// single 32x32 multiplier, then makes the sixteen products of the two-row
// update through one shared multiplier and streams the rows. A translation
// reads, updates and writes back one row, then streams the rows. Axis code 3
// is taken and dropped. A new beat is taken once the previous item has handed
// its last row to the output register.
module rigid_transform_accumulator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rta_pkg::rta_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rta_pkg::rta_out_t out_data
);
    import rta_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TRIG = 4'd1;
    localparam logic [3:0] S_RDA  = 4'd2;
    localparam logic [3:0] S_RDB  = 4'd3;
    localparam logic [3:0] S_LB   = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_WRA  = 4'd6;
    localparam logic [3:0] S_WRB  = 4'd7;
    localparam logic [3:0] S_TRD  = 4'd8;
    localparam logic [3:0] S_TWR  = 4'd9;
    localparam logic [3:0] S_ERD  = 4'd10;
    localparam logic [3:0] S_EOUT = 4'd11;

    logic [3:0]           state_reg, state_next;
    logic [1:0]           axis_reg, axis_next;
    rta_elem_t            amt_reg, amt_next;
    logic [1:0]           erow_reg, erow_next;
    logic [4:0]           mstep_reg, mstep_next;
    logic                 pv_reg, pv_next;
    logic [1:0]           pj_reg, pj_next;
    logic [1:0]           pph_reg, pph_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 pneg_reg, pneg_next;
    rta_elem_t            tmp_reg, tmp_next;
    rta_row_t             pa_reg, pa_next;
    rta_row_t             pb_reg, pb_next;
    rta_row_t             na_reg, na_next;
    rta_row_t             nb_reg, nb_next;
    logic [POSE_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic [1:0]           rd_row_reg, rd_row_next;
    rta_out_t             out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic         ram_we, ram_re;
    logic [1:0]   ram_waddr, ram_raddr;
    rta_row_t     ram_wdata, ram_rdata;
    logic         trig_start, trig_done;
    rta_sc_t      trig_sc;
    logic         out_load;
    logic [1:0]   ra, rb;
    rta_row_t     merged, trow, orow;
    logic [1:0]   mj, mph;
    rta_elem_t    m_elem, ua, mc, msum;
    logic signed [COEF_W-1:0] m_coef;
    logic [COEF_W-2:0] uc;
    logic [COEF_W-1:0] uc_full;

    rta_ram #(
        .WIDTH (ROW_W),
        .DEPTH (POSE_ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rta_trig u_trig (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (trig_start),
        .amount (in_data.amount),
        .done   (trig_done),
        .sc     (trig_sc)
    );

    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                ra = 2'd1;
                rb = 2'd2;
            end
            AXIS_Y:
            begin
                ra = 2'd2;
                rb = 2'd0;
            end
            default:
            begin
                ra = 2'd0;
                rb = 2'd1;
            end
        endcase
    end

    assign merged = rd_valid_reg ? ram_rdata : rta_ident_row(rd_row_reg);

    assign mj  = mstep_reg[3:2];
    assign mph = mstep_reg[1:0];

    always_comb
    begin
        m_elem = mph[0] ? pb_reg[mj] : pa_reg[mj];
        unique case (mph)
            2'd0:    m_coef = trig_sc.c;
            2'd1:    m_coef = -trig_sc.s;
            2'd2:    m_coef = trig_sc.s;
            default: m_coef = trig_sc.c;
        endcase
    end

    assign ua      = m_elem[ELEM_W-1] ? (~m_elem + 1'b1) : m_elem;
    assign uc_full = m_coef[COEF_W-1] ? (~m_coef + 1'b1) : m_coef;
    assign uc      = uc_full[COEF_W-2:0];
    assign mc      = rta_mul_round(prod_reg, pneg_reg);
    assign msum    = rta_sat_add(tmp_reg, mc);

    always_comb
    begin
        trow    = merged;
        trow[3] = rta_sat_add(merged[3], amt_reg);
        orow    = (erow_reg == ROW_LAST) ? rta_ident_row(ROW_LAST) : merged;
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_EOUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        amt_next       = amt_reg;
        erow_next      = erow_reg;
        mstep_next     = mstep_reg;
        pv_next        = pv_reg;
        pj_next        = pj_reg;
        pph_next       = pph_reg;
        prod_next      = prod_reg;
        pneg_next      = pneg_reg;
        tmp_next       = tmp_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        na_next        = na_reg;
        nb_next        = nb_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = ra;
        ram_raddr      = ra;
        ram_wdata      = na_reg;
        trig_start     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    axis_next = in_data.axis;
                    amt_next  = in_data.amount;
                    if (in_data.axis != AXIS_NONE)
                    begin
                        if (in_data.action == ACT_ROTATE)
                        begin
                            trig_start = 1'b1;
                            state_next = S_TRIG;
                        end
                        else
                            state_next = S_TRD;
                    end
                end
            end
            S_TRIG:
            begin
                if (trig_done)
                    state_next = S_RDA;
            end
            S_RDA:
            begin
                ram_re     = 1'b1;
                ram_raddr  = ra;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                pa_next    = merged;
                ram_re     = 1'b1;
                ram_raddr  = rb;
                state_next = S_LB;
            end
            S_LB:
            begin
                pb_next    = merged;
                mstep_next = '0;
                pv_next    = 1'b0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (pv_reg)
                begin
                    if (!pph_reg[0])
                        tmp_next = mc;
                    else if (pph_reg == 2'd1)
                        na_next[pj_reg] = msum;
                    else
                        nb_next[pj_reg] = msum;
                end
                if (!mstep_reg[4])
                begin
                    prod_next  = PROD_W'(ua) * PROD_W'(uc);
                    pneg_next  = m_elem[ELEM_W-1] ^ m_coef[COEF_W-1];
                    pj_next    = mj;
                    pph_next   = mph;
                    pv_next    = 1'b1;
                    mstep_next = mstep_reg + 1'b1;
                end
                else
                begin
                    pv_next    = 1'b0;
                    state_next = S_WRA;
                end
            end
            S_WRA:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ra;
                ram_wdata  = na_reg;
                state_next = S_WRB;
            end
            S_WRB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = rb;
                ram_wdata  = nb_reg;
                erow_next  = '0;
                state_next = S_ERD;
            end
            S_TRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = axis_reg;
                state_next = S_TWR;
            end
            S_TWR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = axis_reg;
                ram_wdata  = trow;
                erow_next  = '0;
                state_next = S_ERD;
            end
            S_ERD:
            begin
                if (erow_reg != ROW_LAST)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = erow_reg;
                end
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_load)
                begin
                    out_next.row_index = erow_reg;
                    out_next.col0      = orow[0];
                    out_next.col1      = orow[1];
                    out_next.col2      = orow[2];
                    out_next.col3      = orow[3];
                    out_next.last_row  = (erow_reg == ROW_LAST);
                    if (erow_reg == ROW_LAST)
                        state_next = S_IDLE;
                    else
                    begin
                        erow_next  = erow_reg + 1'b1;
                        state_next = S_ERD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (ram_we)
            row_valid_next[ram_waddr] = 1'b1;
        rd_valid_next = rd_valid_reg;
        rd_row_next   = rd_row_reg;
        if (ram_re)
        begin
            rd_valid_next = row_valid_reg[ram_raddr];
            rd_row_next   = ram_raddr;
        end
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pv_reg        <= 1'b0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pv_reg        <= pv_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        axis_reg     <= axis_next;
        amt_reg      <= amt_next;
        erow_reg     <= erow_next;
        mstep_reg    <= mstep_next;
        pj_reg       <= pj_next;
        pph_reg      <= pph_next;
        prod_reg     <= prod_next;
        pneg_reg     <= pneg_next;
        tmp_reg      <= tmp_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        na_reg       <= na_next;
        nb_reg       <= nb_next;
        rd_valid_reg <= rd_valid_next;
        rd_row_reg   <= rd_row_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_trig_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        trig_done |-> state_reg == S_TRIG)
        else $error("trig result arrived outside the wait state");

    a_no_row_three_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ram_waddr != ROW_LAST)
        else $error("write to the constant row");

    a_no_row_three_read: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> ram_raddr != ROW_LAST)
        else $error("read of the constant row");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re && ram_waddr == ram_raddr))
        else $error("read and write of one row in the same cycle");

    a_last_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && erow_reg == ROW_LAST) |=> state_reg == S_IDLE && out_valid_reg)
        else $error("last row beat did not return to idle");
`endif
endmodule

FILE: hw/rtl/rta_ram.sv
// rta_ram: generic single-write, single-read memory with registered read data
// no dependencies beyond rta_pkg defaults
module rta_ram #(
    parameter int WIDTH = rta_pkg::ROW_W,
    parameter int DEPTH = rta_pkg::POSE_ROWS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

FILE: hw/rtl/rta_trig.sv
// rta_trig: sequential sine and cosine of an angle in degrees
// angle reduction, octant fold, series on one shared 32x32 multiplier
// depends on rta_pkg
module rta_trig (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  amount,
    output logic                done,
    output rta_pkg::rta_sc_t    sc
);
    import rta_pkg::*;

    localparam int UNIT        = 1 << FRAC_BITS;
    localparam int FULL_TURN   = 2 * HALF_TURN * UNIT;
    localparam int QUARTER     = (HALF_TURN / 2) * UNIT;
    localparam int EIGHTH      = (HALF_TURN / 4) * UNIT;
    localparam int ANG_W       = 32;
    localparam int MOD_STEPS   = 8;
    localparam int CNT_W       = 3;
    localparam int FOLD_W      = $clog2(EIGHTH + 1);
    localparam int FOLD_SHIFT  = 26 - FRAC_BITS;
    localparam int INT_FRAC    = 31;
    localparam int SER_W       = 32;
    localparam int RND_SHIFT   = INT_FRAC - FRAC_BITS;
    localparam int SMAG_W      = FRAC_BITS + 1;
    localparam logic [30:0] RAD_PER_DEG = 31'd1199381129;
    localparam logic [SER_W-1:0] SER_ONE = SER_W'(1) << INT_FRAC;
    localparam logic [ANG_W:0] MOD_BIAS = (ANG_W+1)'(FULL_TURN) << (MOD_STEPS - 1);

    localparam logic [3:0] T_IDLE = 4'd0;
    localparam logic [3:0] T_MOD  = 4'd1;
    localparam logic [3:0] T_FOLD = 4'd2;
    localparam logic [3:0] T_X    = 4'd3;
    localparam logic [3:0] T_X2   = 4'd4;
    localparam logic [3:0] T_P    = 4'd5;
    localparam logic [3:0] T_Q    = 4'd6;
    localparam logic [3:0] T_R    = 4'd7;
    localparam logic [3:0] T_END  = 4'd8;
    localparam logic [3:0] T_SIGN = 4'd9;

    logic [3:0]        st_reg, st_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ANG_W-1:0]  red_reg, red_next;
    logic [1:0]        quad_reg, quad_next;
    logic              swap_reg, swap_next;
    logic [FOLD_W-1:0] fold_reg, fold_next;
    logic [SER_W-1:0]  x_reg, x_next;
    logic [SER_W-1:0]  x2_reg, x2_next;
    logic [SER_W-1:0]  t_reg, t_next;
    logic [SER_W-1:0]  p_reg, p_next;
    logic [SER_W-1:0]  qe_reg, qe_next;
    logic              sin_reg, sin_next;
    logic [SMAG_W-1:0] smag_reg, smag_next;
    logic [SMAG_W-1:0] cmag_reg, cmag_next;
    logic              done_reg, done_next;
    rta_sc_t           sc_reg, sc_next;

    logic [SER_W-1:0]   ma, mb;
    logic [2*SER_W-1:0] prod;
    logic [SER_W-1:0]   prod_sh;
    logic [ANG_W:0]     biased;
    logic [ANG_W-1:0]   full_sh;
    logic [ANG_W-1:0]   ang;
    logic [7:0]         dv;
    logic [SER_W-1:0]   dq, rem, qv, v;
    logic [SER_W:0]     rv;
    logic [SMAG_W-1:0]  mag;
    logic signed [COEF_W-1:0] sp, cp;

    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (st_reg)
            T_X:
            begin
                ma = SER_W'(fold_reg) << FOLD_SHIFT;
                mb = SER_W'(RAD_PER_DEG);
            end
            T_X2:
            begin
                ma = x_reg;
                mb = x_reg;
            end
            T_P:
            begin
                ma = x2_reg;
                mb = t_reg;
            end
            T_Q:
            begin
                ma = p_reg;
                mb = rta_recip(sin_reg, cnt_reg);
            end
            T_END:
            begin
                ma = x_reg;
                mb = t_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod    = ma * mb;
    assign prod_sh = prod[INT_FRAC +: SER_W];
    assign biased  = {amount[31], amount} + (amount[31] ? MOD_BIAS : '0);
    assign full_sh = ANG_W'(FULL_TURN) << cnt_reg;
    assign dv      = rta_div(sin_reg, cnt_reg);
    assign dq      = qe_reg * SER_W'(dv);
    assign rem     = p_reg - dq;
    assign qv      = qe_reg + SER_W'(rem >= SER_W'(dv));
    assign v       = sin_reg ? prod_sh : t_reg;
    assign rv      = {1'b0, v} + ((SER_W+1)'(1) << (RND_SHIFT - 1));
    assign mag     = rv[RND_SHIFT +: SMAG_W];
    assign sp      = COEF_W'(smag_reg);
    assign cp      = COEF_W'(cmag_reg);

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        red_next  = red_reg;
        quad_next = quad_reg;
        swap_next = swap_reg;
        fold_next = fold_reg;
        x_next    = x_reg;
        x2_next   = x2_reg;
        t_next    = t_reg;
        p_next    = p_reg;
        qe_next   = qe_reg;
        sin_next  = sin_reg;
        smag_next = smag_reg;
        cmag_next = cmag_reg;
        done_next = 1'b0;
        sc_next   = sc_reg;
        ang       = red_reg;
        unique case (st_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    red_next = biased[ANG_W-1:0];
                    cnt_next = CNT_W'(MOD_STEPS - 1);
                    st_next  = T_MOD;
                end
            end
            T_MOD:
            begin
                if (red_reg >= full_sh)
                    red_next = red_reg - full_sh;
                if (cnt_reg == '0)
                    st_next = T_FOLD;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            T_FOLD:
            begin
                if (red_reg < ANG_W'(QUARTER))
                begin
                    quad_next = 2'd0;
                    ang       = red_reg;
                end
                else if (red_reg < ANG_W'(2 * QUARTER))
                begin
                    quad_next = 2'd1;
                    ang       = red_reg - ANG_W'(QUARTER);
                end
                else if (red_reg < ANG_W'(3 * QUARTER))
                begin
                    quad_next = 2'd2;
                    ang       = red_reg - ANG_W'(2 * QUARTER);
                end
                else
                begin
                    quad_next = 2'd3;
                    ang       = red_reg - ANG_W'(3 * QUARTER);
                end
                if (ang <= ANG_W'(EIGHTH))
                begin
                    swap_next = 1'b0;
                    fold_next = ang[FOLD_W-1:0];
                end
                else
                begin
                    swap_next = 1'b1;
                    fold_next = FOLD_W'(ANG_W'(QUARTER) - ang);
                end
                st_next = T_X;
            end
            T_X:
            begin
                x_next  = prod_sh;
                st_next = T_X2;
            end
            T_X2:
            begin
                x2_next  = prod_sh;
                t_next   = SER_ONE;
                sin_next = 1'b1;
                cnt_next = 3'd6;
                st_next  = T_P;
            end
            T_P:
            begin
                p_next  = prod_sh;
                st_next = T_Q;
            end
            T_Q:
            begin
                qe_next = prod_sh;
                st_next = T_R;
            end
            T_R:
            begin
                t_next = SER_ONE - qv;
                if (cnt_reg == 3'd1)
                    st_next = T_END;
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                    st_next  = T_P;
                end
            end
            T_END:
            begin
                if (sin_reg != swap_reg)
                    smag_next = mag;
                else
                    cmag_next = mag;
                if (sin_reg)
                begin
                    sin_next = 1'b0;
                    t_next   = SER_ONE;
                    cnt_next = 3'd7;
                    st_next  = T_P;
                end
                else
                    st_next = T_SIGN;
            end
            T_SIGN:
            begin
                unique case (quad_reg)
                    2'd0:
                    begin
                        sc_next.s = sp;
                        sc_next.c = cp;
                    end
                    2'd1:
                    begin
                        sc_next.s = cp;
                        sc_next.c = -sp;
                    end
                    2'd2:
                    begin
                        sc_next.s = -sp;
                        sc_next.c = -cp;
                    end
                    default:
                    begin
                        sc_next.s = -cp;
                        sc_next.c = sp;
                    end
                endcase
                done_next = 1'b1;
                st_next   = T_IDLE;
            end
            default:
                st_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= T_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        red_reg  <= red_next;
        quad_reg <= quad_next;
        swap_reg <= swap_next;
        fold_reg <= fold_next;
        x_reg    <= x_next;
        x2_reg   <= x2_next;
        t_reg    <= t_next;
        p_reg    <= p_next;
        qe_reg   <= qe_next;
        sin_reg  <= sin_next;
        smag_reg <= smag_next;
        cmag_reg <= cmag_next;
        sc_reg   <= sc_next;
    end

    assign done = done_reg;
    assign sc   = sc_reg;
endmodule

FILE: tb/rta_pose_checker.sv
// rta_pose_checker: watches the input and output channels of the pose accumulator,
// predicts the four pose rows of each accepted beat and compares them field by field
// depends on rta_pkg
module rta_pose_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  rta_pkg::rta_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  rta_pkg::rta_out_t out_data,
    output int                fail_count,
    output int                rows_pending
);
    import rta_pkg::*;

    localparam longint PMAX = 64'sd2147483647;
    localparam longint PMIN = -64'sd2147483648;
    localparam longint PONE = 64'sd65536;

    longint pose [12];
    rta_out_t row_queue [$];

    function automatic longint clamp_add(longint a, longint b);
        longint s;
        s = a + b;
        if (s > PMAX) return PMAX;
        if (s < PMIN) return PMIN;
        return s;
    endfunction

    function automatic longint scale_coef(longint a, longint c);
        longint ua, uc, mag;
        logic neg;
        neg = (a < 0) != (c < 0);
        ua = a < 0 ? -a : a;
        uc = c < 0 ? -c : c;
        mag = (ua * uc + 64'sd32768) >>> 16;
        if (neg) return (mag >= PMAX + 1) ? PMIN : -mag;
        return (mag > PMAX) ? PMAX : mag;
    endfunction

    function automatic longint unsigned taylor(longint unsigned x, logic want_sin);
        longint unsigned one, x2, t;
        int k;
        one = 64'd1 << 31;
        x2 = (x * x) >> 31;
        t = one;
        if (want_sin)
        begin
            for (k = 6; k >= 1; k--)
                t = one - ((x2 * t) >> 31) / ((2 * k) * (2 * k + 1));
            return (x * t) >> 31;
        end
        for (k = 7; k >= 1; k--)
            t = one - ((x2 * t) >> 31) / ((2 * k - 1) * (2 * k));
        return t;
    endfunction

    function automatic longint folded_trig(longint deg, logic want_sin);
        longint unsigned x, v;
        x = ((longint'(deg) << 10) * 64'd1199381129) >> 31;
        v = taylor(x, want_sin);
        v = (v + (64'd1 << 14)) >> 15;
        return longint'(v);
    endfunction

    task automatic angle_sin_cos(input longint amt, output longint s, output longint c);
        longint full, quarter, eighth, r, a, s0, c0;
        int q;
        full = 360 * PONE;
        quarter = 90 * PONE;
        eighth = 45 * PONE;
        r = amt % full;
        if (r < 0) r += full;
        q = int'(r / quarter);
        a = r - q * quarter;
        if (a <= eighth)
        begin
            s0 = folded_trig(a, 1'b1);
            c0 = folded_trig(a, 1'b0);
        end
        else
        begin
            s0 = folded_trig(quarter - a, 1'b0);
            c0 = folded_trig(quarter - a, 1'b1);
        end
        case (q & 3)
            0: begin s = s0; c = c0; end
            1: begin s = c0; c = -s0; end
            2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endtask

    task automatic apply_motion(input rta_in_t beat);
        longint s, c, pa, pb, amt;
        int ra, rb, j, k, ax;
        rta_out_t r;
        if (beat.axis == AXIS_NONE) return;
        ax = int'(beat.axis);
        amt = longint'(beat.amount);
        if (beat.action == ACT_TRANSLATE)
            pose[ax * 4 + 3] = clamp_add(pose[ax * 4 + 3], amt);
        else
        begin
            ra = (ax + 1) % 3;
            rb = (ax + 2) % 3;
            angle_sin_cos(amt, s, c);
            for (j = 0; j < 4; j++)
            begin
                pa = pose[ra * 4 + j];
                pb = pose[rb * 4 + j];
                pose[ra * 4 + j] = clamp_add(scale_coef(pa, c), scale_coef(pb, -s));
                pose[rb * 4 + j] = clamp_add(scale_coef(pa, s), scale_coef(pb, c));
            end
        end
        for (k = 0; k < 4; k++)
        begin
            r.row_index = 2'(k);
            r.col0 = (k < 3) ? 32'(pose[k * 4 + 0]) : 32'sd0;
            r.col1 = (k < 3) ? 32'(pose[k * 4 + 1]) : 32'sd0;
            r.col2 = (k < 3) ? 32'(pose[k * 4 + 2]) : 32'sd0;
            r.col3 = (k < 3) ? 32'(pose[k * 4 + 3]) : 32'(PONE);
            r.last_row = (k == 3);
            row_queue.push_back(r);
        end
    endtask

    assign rows_pending = row_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        rta_out_t exp_row;
        if (!rst_n)
        begin
            for (int i = 0; i < 12; i++)
                pose[i] = (i % 5 == 0) ? PONE : 0;
            row_queue.delete();
            fail_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_motion(in_data);
            if (out_valid && out_ready)
            begin
                if (row_queue.size() == 0)
                begin
                    $error("unexpected output beat %p", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_row = row_queue.pop_front();
                    if (out_data !== exp_row)
                    begin
                        if (out_data.row_index !== exp_row.row_index)
                            $error("row_index expected %0d got %0d", exp_row.row_index,
                                   out_data.row_index);
                        if (out_data.col0 !== exp_row.col0)
                            $error("col0 expected %0d got %0d", exp_row.col0, out_data.col0);
                        if (out_data.col1 !== exp_row.col1)
                            $error("col1 expected %0d got %0d", exp_row.col1, out_data.col1);
                        if (out_data.col2 !== exp_row.col2)
                            $error("col2 expected %0d got %0d", exp_row.col2, out_data.col2);
                        if (out_data.col3 !== exp_row.col3)
                            $error("col3 expected %0d got %0d", exp_row.col3, out_data.col3);
                        if (out_data.last_row !== exp_row.last_row)
                            $error("last_row expected %0d got %0d", exp_row.last_row,
                                   out_data.last_row);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb_rigid_transform_accumulator.sv
// tb_rigid_transform_accumulator: drives random rotations and translations into the
// pose accumulator with random gaps and stalls, and reports the verdict
// depends on rta_pkg, rigid_transform_accumulator, rta_pose_checker
module tb_rigid_transform_accumulator;
    import rta_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    rta_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    rta_out_t out_data;
    int       fail_count;
    int       rows_pending;
    logic     out_hold;

    rigid_transform_accumulator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    rta_pose_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .rows_pending (rows_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8000000;
        $display("simulation failed");
        $finish;
    end

    // receiver stall: a random wait before each beat, none while out_hold is set
    initial
    begin
        int wait_cycles;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                wait_cycles = out_hold ? 0 : $urandom_range(0, 8);
                repeat (wait_cycles) @(posedge clk);
                out_ready <= 1'b1;
                do @(posedge clk); while (!out_valid);
                out_ready <= 1'b0;
            end
        end
    end

    // valid drops only when a gap follows, so back to back beats keep it high
    task automatic send_beat(input logic act, input logic [1:0] ax, input logic [31:0] amt);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{action: act, axis: ax, amount: amt};
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic logic [31:0] pick_amount(logic act);
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 720)) - 360) << 16;
            2: return 32'(45 << 16) + 32'($signed($urandom_range(0, 4)) - 2);
            3: return act ? 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000)
                          : 32'($urandom_range(0, 90)) << 16;
            default: return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
        endcase
    endfunction

    initial
    begin
        logic act;
        logic [1:0] ax;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_hold = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_beat(ACT_ROTATE, AXIS_X, 32'h0000_0000);
        send_beat(ACT_ROTATE, AXIS_Y, 32'(90 << 16));
        send_beat(ACT_ROTATE, AXIS_Z, 32'(45 << 16));
        send_beat(ACT_ROTATE, AXIS_X, 32'(180 << 16));
        send_beat(ACT_ROTATE, AXIS_Y, 32'(270 << 16));
        send_beat(ACT_ROTATE, AXIS_Z, 32'(360 << 16));
        send_beat(ACT_ROTATE, AXIS_X, 32'h8000_0000);
        send_beat(ACT_ROTATE, AXIS_Y, 32'h7fff_ffff);
        send_beat(ACT_ROTATE, AXIS_Z, -32'sd1);
        send_beat(ACT_ROTATE, AXIS_NONE, 32'(30 << 16));
        send_beat(ACT_TRANSLATE, AXIS_NONE, 32'h7fff_ffff);
        send_beat(ACT_TRANSLATE, AXIS_X, 32'h7fff_ffff);
        send_beat(ACT_TRANSLATE, AXIS_X, 32'h7fff_ffff);
        send_beat(ACT_TRANSLATE, AXIS_Y, 32'h8000_0000);
        send_beat(ACT_TRANSLATE, AXIS_Y, 32'h8000_0000);
        send_beat(ACT_TRANSLATE, AXIS_Z, 32'h0001_0000);
        send_beat(ACT_ROTATE, AXIS_Z, 32'(30 << 16));
        send_beat(ACT_ROTATE, AXIS_X, -32'sd2949120);
        send_beat(ACT_TRANSLATE, AXIS_Z, 32'hffff_0000);
        send_beat(ACT_TRANSLATE, AXIS_X, 32'h8000_0000);
        for (int n = 0; n < 460; n++)
        begin
            act = $urandom_range(0, 1);
            ax = ($urandom_range(0, 15) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
            if ($urandom_range(0, 40) == 0) out_hold <= ~out_hold;
            send_beat(act, ax, pick_amount(act));
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (rows_pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && rows_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
